// File: design/lkvt_pkg.sv
`timescale 1ns / 1ps

package lkvt_pkg;

  localparam int KEY_W  = 64;
  localparam int DATA_W = 32;

  // Action field codes on the input stream
  localparam logic [1:0] ACT_PUT = 2'd0;
  localparam logic [1:0] ACT_GET = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_GET,
    OP_DEL,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_DELW,
    S_DONE
  } eng_state_t;

endpackage

// File: design/lkvt_front.sv
`timescale 1ns / 1ps

module lkvt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [lkvt_pkg::KEY_W-1:0]  in_key,
  input  logic [lkvt_pkg::DATA_W-1:0] in_value,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output lkvt_pkg::cmd_t        cmd
);
  import lkvt_pkg::*;

  logic hold_valid;
  cmd_t cmd_r;
  cmd_t decoded;

  always_comb begin
    decoded.key   = in_key;
    decoded.value = in_value;
    case (in_action)
      ACT_PUT: decoded.op = OP_PUT;
      ACT_GET: decoded.op = OP_GET;
      ACT_DEL: decoded.op = OP_DEL;
      default: decoded.op = OP_NOP;
    endcase
  end

  assign in_ready  = !hold_valid || cmd_ready;
  assign cmd_valid = hold_valid;
  assign cmd       = cmd_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= 1'b1;
    end else if (cmd_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= decoded;
    end
  end

endmodule

// File: design/lkvt_queue.sv
`timescale 1ns / 1ps

module lkvt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lkvt_pkg::cmd_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lkvt_pkg::cmd_t out_data
);
  import lkvt_pkg::*;

  cmd_t       slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

// File: design/lkvt_engine.sv
`timescale 1ns / 1ps

module lkvt_engine #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  lkvt_pkg::cmd_t              cmd_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output lkvt_pkg::status_t           out_status,
  output logic [lkvt_pkg::DATA_W-1:0] out_value
);
  import lkvt_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [KEY_W-1:0]       key_mem [0:DEPTH-1];
  logic [VALUE_WIDTH-1:0] val_mem [0:DEPTH-1];
  logic [KEY_W-1:0]       key_rd;
  logic [VALUE_WIDTH-1:0] val_rd;

  eng_state_t        state, state_next;
  cmd_t              cmd, cmd_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     ptr, ptr_next;
  logic              cmp_valid, cmp_valid_next;
  logic [IW-1:0]     cmp_idx, cmp_idx_next;
  logic              hit, hit_next;
  logic [IW-1:0]     hit_idx, hit_idx_next;
  status_t           status, status_next;
  logic [DATA_W-1:0] rdval, rdval_next;
  logic              out_valid_next;
  status_t           out_status_next;
  logic [DATA_W-1:0] out_value_next;

  logic                   match;
  logic [IW-1:0]          rd_addr;
  logic [IW-1:0]          wr_addr;
  logic                   key_we;
  logic                   val_we;
  logic [KEY_W-1:0]       key_wdata;
  logic [VALUE_WIDTH-1:0] val_wdata;
  logic [CW-1:0]          last;

  assign match = cmp_valid && (key_rd == cmd.key);
  assign last  = count - CW'(1);

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    count_next      = count;
    ptr_next        = ptr;
    cmp_valid_next  = 1'b0;
    cmp_idx_next    = cmp_idx;
    hit_next        = hit;
    hit_idx_next    = hit_idx;
    status_next     = status;
    rdval_next      = rdval;
    out_valid_next  = out_valid && !out_ready;
    out_status_next = out_status;
    out_value_next  = out_value;
    cmd_ready       = 1'b0;
    rd_addr         = ptr[IW-1:0];
    wr_addr         = hit_idx;
    key_we          = 1'b0;
    val_we          = 1'b0;
    key_wdata       = cmd.key;
    val_wdata       = VALUE_WIDTH'(cmd.value);

    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        ptr_next  = '0;
        if (cmd_valid) begin
          cmd_next    = cmd_in;
          status_next = ST_OK;
          rdval_next  = '0;
          state_next  = S_SCAN;
        end
      end

      // read issue and compare overlap: data for cmp_idx arrives in the cycle after issue
      S_SCAN: begin
        if (match) begin
          hit_next     = 1'b1;
          hit_idx_next = cmp_idx;
          if (cmd.op == OP_GET) begin
            rdval_next = DATA_W'(val_rd);
          end
          state_next = S_EXEC;
        end else if (ptr < count) begin
          ptr_next       = ptr + CW'(1);
          cmp_valid_next = 1'b1;
          cmp_idx_next   = ptr[IW-1:0];
        end else begin
          hit_next   = 1'b0;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_DONE;
        case (cmd.op)
          OP_PUT: begin
            if (hit) begin
              val_we = 1'b1;
            end else if (count == FULL_COUNT) begin
              status_next = ST_FULL;
            end else begin
              wr_addr    = count[IW-1:0];
              key_we     = 1'b1;
              val_we     = 1'b1;
              count_next = count + CW'(1);
            end
          end
          OP_GET: begin
            if (!hit) begin
              status_next = ST_MISSING;
            end
          end
          OP_DEL: begin
            if (hit) begin
              rd_addr    = last[IW-1:0];
              state_next = S_DELW;
            end else begin
              status_next = ST_MISSING;
            end
          end
          default: begin
          end
        endcase
      end

      // last entry is on the read port; move it into the freed slot
      S_DELW: begin
        key_we     = 1'b1;
        val_we     = 1'b1;
        key_wdata  = key_rd;
        val_wdata  = val_rd;
        count_next = last;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          out_status_next = status;
          out_value_next  = rdval;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    ptr        <= ptr_next;
    cmp_idx    <= cmp_idx_next;
    hit        <= hit_next;
    hit_idx    <= hit_idx_next;
    status     <= status_next;
    rdval      <= rdval_next;
    out_status <= out_status_next;
    out_value  <= out_value_next;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    key_rd <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= val_wdata;
    end
    val_rd <= val_mem[rd_addr];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> ($past(state) == S_EXEC || $past(state) == S_DELW))
    else $error("entry count changed outside execute");

  a_hit_live: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && match) |-> ({1'b0, cmp_idx} < {1'b0, count}))
    else $error("hit on a slot beyond the live entries");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside done state");

endmodule

// File: design/linear_key_value_table_unit.sv
`timescale 1ns / 1ps
// Path: an item passes the front register and the queue, then the engine scans the
// live entries through the key memory read port, then runs its execute and result
// stages (delete adds a step that moves the last entry into the freed slot).
// Concurrency: one item at a time in the scan engine; others wait in front and queue.
// Reset: synchronous, active high; empties the table (entry count to zero).

module linear_key_value_table_unit #(
  parameter int DEPTH       = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // [63:0] key, [95:64] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] read_value
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import lkvt_pkg::*;

  logic    front_valid;
  logic    front_ready;
  cmd_t    front_cmd;
  logic    q_valid;
  logic    q_ready;
  cmd_t    q_cmd;
  status_t status;

  lkvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tuser),
    .in_key    (s_axis_tdata[KEY_W-1:0]),
    .in_value  (s_axis_tdata[KEY_W+DATA_W-1:KEY_W]),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  lkvt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_cmd)
  );

  lkvt_engine #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_in     (q_cmd),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (status),
    .out_value  (m_axis_tdata)
  );

  assign m_axis_tuser = status;

endmodule
